### hw/rtl/hlsu_pkg.sv
`timescale 1ns / 1ps
package hlsu_pkg;

    // Request opcodes
    typedef enum logic [1:0] {
        OP_EXEC = 2'd0,
        OP_RET  = 2'd1,
        OP_WREG = 2'd2,
        OP_RREG = 2'd3
    } t_op;

    // Response kinds
    typedef enum logic [1:0] {
        KIND_READ     = 2'd0,
        KIND_WRITE    = 2'd1,
        KIND_DONE     = 2'd2,
        KIND_READBACK = 2'd3
    } t_kind;

    // Completion status
    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_SWAP   = 3'd1,
        ST_DWORD  = 3'd2,
        ST_RSVD   = 3'd3,
        ST_NOPEND = 3'd4,
        ST_BUSY   = 3'd5
    } t_status;

    // SH field values
    localparam logic [1:0] SH_SWP  = 2'd0;
    localparam logic [1:0] SH_SB   = 2'd2;
    localparam logic [1:0] SH_SH   = 2'd3;

    localparam logic [3:0]  PC_REG     = 4'd15;
    localparam logic [15:0] PC_STORE_OFS = 16'd12;

    typedef struct packed {
        t_op         opcode;
        logic [31:0] instruction;
        logic [31:0] instruction_address;
        logic [3:0]  reg_index;
        logic [31:0] reg_value;
        logic [15:0] load_data;
    } t_req;

    typedef struct packed {
        t_kind       result_kind;
        logic [31:0] bus_address;
        logic        access_size;
        logic [15:0] store_data;
        logic [31:0] read_value;
        t_status     status;
        logic [3:0]  warn_bits;
        logic        pc_written;
        logic [31:0] new_pc;
    } t_rsp;

    // One register file write
    typedef struct packed {
        logic        en;
        logic [3:0]  addr;
        logic [31:0] data;
    } t_wr;

endpackage

### hw/rtl/hlsu_if.sv
`timescale 1ns / 1ps
// Request channel into the unit
interface hlsu_req_if;
    logic               valid;
    logic               ready;
    hlsu_pkg::t_req     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// Response channel out of the unit
interface hlsu_rsp_if;
    logic               valid;
    logic               ready;
    hlsu_pkg::t_rsp     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

### hw/rtl/hlsu_ram.sv
`timescale 1ns / 1ps
// Generic RAM: one write port, two registered read ports, read-before-write
module hlsu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr_a,
    input  logic [AW-1:0]    i_raddr_b,
    output logic [WIDTH-1:0] o_rdata_a,
    output logic [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

### hw/rtl/halfword_load_store_unit.sv
`timescale 1ns / 1ps
// Requests are registered in stage 1, then in the output register. Throughput:
// one request per cycle unless the output stalls; a data return writing back
// another base writes it first, as the register file has one write port.
// Reset (synchronous, active low) clears the pipeline, the pending-load flag
// and the register valid bits, so every register reads as zero until written.
module halfword_load_store_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hlsu_req_if.sink   i_req,
    hlsu_rsp_if.source o_rsp
);

    // Read ports: 0 base Rn, 1 offset Rm, 2 store source Rd, 3 readback index
    localparam int NPORT = 4;

    logic                 in_fire;
    logic                 in_ready;
    logic                 out_free;
    logic                 s1_fire;
    logic                 s1_last;
    logic                 wr_go;
    logic                 pend_set;
    logic                 pend_clr;

    logic                 r_s1_vld;
    hlsu_pkg::t_req       r_s1;
    logic [NPORT-1:0]     r_s1_rvld;
    logic                 r_ph;

    logic [15:0]          r_rf_vld;
    logic                 r_fw_vld;
    logic [3:0]           r_fw_addr;
    logic [31:0]          r_fw_data;

    logic                 r_pend_vld;
    logic [3:0]           r_pend_dest;
    logic [1:0]           r_pend_type;
    logic [3:0]           r_pend_base;
    logic [31:0]          r_pend_new_base;
    logic                 r_pend_wb;

    logic                 r_out_vld;
    hlsu_pkg::t_rsp       r_out;

    logic [3:0]           rd_addr [NPORT];
    logic [3:0]           s1_addr [NPORT];
    logic [31:0]          ram_q   [NPORT];
    logic [31:0]          s1_val  [NPORT];

    hlsu_pkg::t_rsp       s1_rsp;
    hlsu_pkg::t_wr        s1_wr;

    // Decode fields of the item in stage 1
    logic                 d_l, d_p, d_u, d_imm, d_w, d_wb;
    logic [1:0]           d_sh;
    logic [3:0]           d_rn, d_rd;
    logic [31:0]          d_off, d_moved, d_addr;
    logic [3:0]           d_warn;
    logic [15:0]          d_sdata;
    logic [31:0]          d_ext;

    // Handshake
    assign out_free  = !r_out_vld || o_rsp.ready;
    assign s1_fire   = r_s1_vld && s1_last && out_free;
    assign in_ready  = !r_s1_vld || s1_fire;
    assign in_fire   = i_req.valid && in_ready;
    assign i_req.ready = in_ready;

    // Read addresses come straight from the request
    assign rd_addr[0] = i_req.payload.instruction[19:16];
    assign rd_addr[1] = i_req.payload.instruction[3:0];
    assign rd_addr[2] = i_req.payload.instruction[15:12];
    assign rd_addr[3] = i_req.payload.reg_index;

    assign s1_addr[0] = r_s1.instruction[19:16];
    assign s1_addr[1] = r_s1.instruction[3:0];
    assign s1_addr[2] = r_s1.instruction[15:12];
    assign s1_addr[3] = r_s1.reg_index;

    // Two copies of the register file, written together
    hlsu_ram #(
        .WIDTH (32),
        .DEPTH (16)
    ) u_rf_ab (
        .i_clk     (i_clk),
        .i_we      (wr_go),
        .i_waddr   (s1_wr.addr),
        .i_wdata   (s1_wr.data),
        .i_re      (in_fire),
        .i_raddr_a (rd_addr[0]),
        .i_raddr_b (rd_addr[1]),
        .o_rdata_a (ram_q[0]),
        .o_rdata_b (ram_q[1])
    );

    hlsu_ram #(
        .WIDTH (32),
        .DEPTH (16)
    ) u_rf_cd (
        .i_clk     (i_clk),
        .i_we      (wr_go),
        .i_waddr   (s1_wr.addr),
        .i_wdata   (s1_wr.data),
        .i_re      (in_fire),
        .i_raddr_a (rd_addr[2]),
        .i_raddr_b (rd_addr[3]),
        .o_rdata_a (ram_q[2]),
        .o_rdata_b (ram_q[3])
    );

    // Forward the last write (the RAM returns old data on a same-edge write);
    // unwritten registers read as zero
    always_comb begin
        for (int i = 0; i < NPORT; i++) begin
            if (r_fw_vld && r_fw_addr == s1_addr[i]) begin
                s1_val[i] = r_fw_data;
            end else if (r_s1_rvld[i]) begin
                s1_val[i] = ram_q[i];
            end else begin
                s1_val[i] = '0;
            end
        end
    end

    // Addressing and extension datapath
    always_comb begin
        d_l     = r_s1.instruction[20];
        d_p     = r_s1.instruction[24];
        d_u     = r_s1.instruction[23];
        d_imm   = r_s1.instruction[22];
        d_w     = r_s1.instruction[21];
        d_sh    = r_s1.instruction[6:5];
        d_rn    = r_s1.instruction[19:16];
        d_rd    = r_s1.instruction[15:12];
        d_off   = d_imm ? {24'd0, r_s1.instruction[11:8], r_s1.instruction[3:0]}
                        : s1_val[1];
        d_moved = d_u ? s1_val[0] + d_off : s1_val[0] - d_off;
        d_addr  = d_p ? d_moved : s1_val[0];
        d_wb    = d_p ? d_w : 1'b1;
        d_warn  = '0;
        d_warn[0] = !d_imm && (r_s1.instruction[11:8] != 4'd0);
        d_warn[1] = !d_imm && (r_s1.instruction[3:0] == hlsu_pkg::PC_REG);
        d_warn[2] = !d_p && d_w;
        d_sdata = (d_rd == hlsu_pkg::PC_REG)
                ? r_s1.instruction_address[15:0] + hlsu_pkg::PC_STORE_OFS
                : s1_val[2][15:0];
        case (r_pend_type)
            hlsu_pkg::SH_SB: d_ext = {{24{r_s1.load_data[7]}}, r_s1.load_data[7:0]};
            hlsu_pkg::SH_SH: d_ext = {{16{r_s1.load_data[15]}}, r_s1.load_data};
            default:         d_ext = {16'd0, r_s1.load_data};
        endcase
    end

    // Stage 1 control: response, register write, pending-load updates
    always_comb begin
        s1_rsp             = '0;
        s1_rsp.result_kind = hlsu_pkg::KIND_DONE;
        s1_rsp.status      = hlsu_pkg::ST_OK;
        s1_wr              = '0;
        s1_last            = 1'b1;
        pend_set           = 1'b0;
        pend_clr           = 1'b0;
        case (r_s1.opcode)
            hlsu_pkg::OP_EXEC: begin
                if (r_pend_vld) begin
                    s1_rsp.status = hlsu_pkg::ST_BUSY;
                end else if (!d_l && d_sh == hlsu_pkg::SH_SWP) begin
                    s1_rsp.status = hlsu_pkg::ST_SWAP;
                end else if (!d_l && d_sh[1]) begin
                    s1_rsp.status = hlsu_pkg::ST_DWORD;
                end else if (d_l && d_sh == hlsu_pkg::SH_SWP) begin
                    s1_rsp.status = hlsu_pkg::ST_RSVD;
                end else if (!d_l) begin
                    // halfword store
                    s1_rsp.result_kind = hlsu_pkg::KIND_WRITE;
                    s1_rsp.bus_address = {d_addr[31:1], 1'b0};
                    s1_rsp.access_size = 1'b1;
                    s1_rsp.store_data  = d_sdata;
                    s1_rsp.warn_bits   = d_warn;
                    s1_wr.en           = d_wb;
                    s1_wr.addr         = d_rn;
                    s1_wr.data         = d_moved;
                end else begin
                    // load: park until the data returns
                    pend_set           = 1'b1;
                    s1_rsp.result_kind = hlsu_pkg::KIND_READ;
                    s1_rsp.warn_bits   = {d_rd == hlsu_pkg::PC_REG, d_warn[2:0]};
                    if (d_sh == hlsu_pkg::SH_SB) begin
                        s1_rsp.bus_address = d_addr;
                        s1_rsp.access_size = 1'b0;
                    end else begin
                        s1_rsp.bus_address = {d_addr[31:1], 1'b0};
                        s1_rsp.access_size = 1'b1;
                    end
                end
            end
            hlsu_pkg::OP_RET: begin
                if (!r_pend_vld) begin
                    s1_rsp.status = hlsu_pkg::ST_NOPEND;
                end else if (r_pend_wb && r_pend_base != r_pend_dest && !r_ph) begin
                    // first pass: base writeback only
                    s1_last    = 1'b0;
                    s1_wr.en   = 1'b1;
                    s1_wr.addr = r_pend_base;
                    s1_wr.data = r_pend_new_base;
                end else begin
                    pend_clr          = 1'b1;
                    s1_wr.en          = 1'b1;
                    s1_wr.addr        = r_pend_dest;
                    s1_wr.data        = d_ext;
                    s1_rsp.read_value = d_ext;
                    if (r_pend_dest == hlsu_pkg::PC_REG) begin
                        s1_rsp.pc_written = 1'b1;
                        s1_rsp.new_pc     = {d_ext[31:2], 2'b00};
                    end
                end
            end
            hlsu_pkg::OP_WREG: begin
                s1_wr.en   = 1'b1;
                s1_wr.addr = r_s1.reg_index;
                s1_wr.data = r_s1.reg_value;
            end
            hlsu_pkg::OP_RREG: begin
                s1_rsp.result_kind = hlsu_pkg::KIND_READBACK;
                s1_rsp.read_value  = s1_val[3];
            end
            default: ;
        endcase
    end

    // A first-pass write goes at once; the last write waits for the output slot
    assign wr_go = r_s1_vld && s1_wr.en && (s1_last ? out_free : 1'b1);

    // Stage 1 register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_ph     <= 1'b0;
        end else begin
            if (in_fire) begin
                r_s1_vld <= 1'b1;
            end else if (s1_fire) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_fire) begin
                r_ph <= 1'b0;
            end else if (r_s1_vld && !s1_last) begin
                r_ph <= 1'b1;
            end
        end
        if (in_fire) begin
            r_s1 <= i_req.payload;
            for (int i = 0; i < NPORT; i++) begin
                r_s1_rvld[i] <= r_rf_vld[rd_addr[i]];
            end
        end
    end

    // Register valid bits and write forwarding
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rf_vld <= '0;
            r_fw_vld <= 1'b0;
        end else if (wr_go) begin
            r_rf_vld[s1_wr.addr] <= 1'b1;
            r_fw_vld             <= 1'b1;
        end
        if (wr_go) begin
            r_fw_addr <= s1_wr.addr;
            r_fw_data <= s1_wr.data;
        end
    end

    // Pending load
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_vld      <= 1'b0;
            r_pend_dest     <= '0;
            r_pend_type     <= '0;
            r_pend_base     <= '0;
            r_pend_new_base <= '0;
            r_pend_wb       <= 1'b0;
        end else if (s1_fire && pend_set) begin
            r_pend_vld      <= 1'b1;
            r_pend_dest     <= d_rd;
            r_pend_type     <= d_sh;
            r_pend_base     <= d_rn;
            r_pend_new_base <= d_moved;
            r_pend_wb       <= d_wb;
        end else if (s1_fire && pend_clr) begin
            r_pend_vld      <= 1'b0;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s1_fire) begin
            r_out_vld <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_vld <= 1'b0;
        end
        if (s1_fire) begin
            r_out <= s1_rsp;
        end
    end

    assign o_rsp.valid   = r_out_vld;
    assign o_rsp.payload = r_out;

endmodule

### hw/rtl/hlsu_checker.sv
`timescale 1ns / 1ps
module hlsu_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           i_in_ready,
    input logic           i_out_valid,
    input logic           i_out_ready,
    input hlsu_pkg::t_rsp i_out
);

    logic       in_acc;
    logic       out_acc;
    logic [1:0] r_cnt;

    assign in_acc  = i_in_valid && i_in_ready;
    assign out_acc = i_out_valid && i_out_ready;

    // Requests in flight: at most stage 1 plus the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= r_cnt + {1'b0, in_acc} - {1'b0, out_acc};
        end
    end

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out))
        else $error("response dropped or changed while stalled");

    a_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt <= 2'd2) && (!out_acc || r_cnt != 2'd0))
        else $error("response without a matching request");

    a_half_even: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out.access_size &&
        (i_out.result_kind == hlsu_pkg::KIND_READ ||
         i_out.result_kind == hlsu_pkg::KIND_WRITE) |-> !i_out.bus_address[0])
        else $error("odd halfword bus address");

    a_pc_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out.pc_written |->
        i_out.new_pc == {i_out.read_value[31:2], 2'b00} &&
        i_out.result_kind == hlsu_pkg::KIND_DONE)
        else $error("program counter not the word-aligned loaded value");

    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("response valid straight after reset");

endmodule

bind halfword_load_store_unit hlsu_checker u_hlsu_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_out       (o_rsp.payload)
);
